/* rtl/core/sfr_pkg.sv */
package sfr_pkg;

	localparam int BUF_DEPTH = 128;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
	localparam int CMP_W     = (FILL_W > 8) ? FILL_W : 8;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_TICK    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_READ    = 2'd3;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_ACCEPT   = 3'd1;
	localparam logic [2:0] EV_BADSUM   = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_OVERFLOW = 3'd4;
	localparam logic [2:0] EV_IGNORED  = 3'd5;

	localparam logic [1:0] CFG_TIMEOUT     = 2'd0;
	localparam logic [1:0] CFG_SYNC_FIRST  = 2'd1;
	localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;

	localparam logic [7:0] TIMEOUT_RESET     = 8'd33;
	localparam logic [7:0] SYNC_FIRST_RESET  = 8'h55;
	localparam logic [7:0] SYNC_SECOND_RESET = 8'hAA;
	localparam logic [7:0] SUM_SEED          = 8'hFF;

	localparam int SYNC2_POS = 1;
	localparam int CMD_POS   = 2;
	localparam int LEN_POS   = 3;

	typedef struct packed {
		logic [7:0] timeout_reload;
		logic [7:0] sync_first;
		logic [7:0] sync_second;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_req_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       frame_ready;
		logic [7:0] position;
		logic [7:0] command;
	} result_t;

endpackage

/* rtl/core/sfr_ram.sv */
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/sfr_ctrl.sv */
module sfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       kind,
	input  logic [7:0]       data,
	input  sfr_pkg::cfg_t    cfg,
	output sfr_pkg::wr_req_t wr,
	output sfr_pkg::result_t res
);

	logic [sfr_pkg::FILL_W-1:0] fill_q, fill_d, fill_inc, fill_put;
	logic [7:0]                 sum_q, sum_d;
	logic                       ready_q, ready_d;
	logic [7:0]                 silence_q, silence_d;
	logic [7:0]                 cmd_q, cmd_d;
	logic [7:0]                 len_q, len_d;
	logic [2:0]                 ev;
	logic                       room;

	always_comb begin
		fill_d    = fill_q;
		sum_d     = sum_q;
		ready_d   = ready_q;
		silence_d = silence_q;
		ev        = sfr_pkg::EV_NONE;
		fill_inc  = fill_q + 1'b1;
		room      = fill_q < sfr_pkg::FILL_W'(sfr_pkg::BUF_DEPTH);
		fill_put  = room ? fill_inc : fill_q;
		wr.en     = 1'b0;
		wr.addr   = sfr_pkg::ADDR_W'(fill_q);
		wr.data   = data;
		case (kind)
			sfr_pkg::KIND_BYTE: begin
				if (ready_q) begin
					ev = sfr_pkg::EV_IGNORED;
				end else begin
					silence_d = cfg.timeout_reload;
					if (fill_q == '0) begin
						if (data == cfg.sync_first) begin
							wr.en  = 1'b1;
							fill_d = fill_inc;
						end
					end else if (fill_q == sfr_pkg::FILL_W'(sfr_pkg::SYNC2_POS)) begin
						wr.en  = 1'b1;
						fill_d = (data == cfg.sync_second) ? fill_inc : '0;
						sum_d  = sfr_pkg::SUM_SEED;
					end else if (fill_q == sfr_pkg::FILL_W'(sfr_pkg::CMD_POS) ||
					             fill_q == sfr_pkg::FILL_W'(sfr_pkg::LEN_POS)) begin
						wr.en  = 1'b1;
						sum_d  = sum_q + data;
						fill_d = fill_inc;
					end else begin
						wr.en = room;
						if (sfr_pkg::CMP_W'(len_q) == sfr_pkg::CMP_W'(fill_put)) begin
							if (sum_q == data) begin
								ready_d = 1'b1;
								fill_d  = fill_put;
								ev      = sfr_pkg::EV_ACCEPT;
							end else begin
								fill_d = '0;
								ev     = sfr_pkg::EV_BADSUM;
							end
						end else begin
							sum_d = sum_q + data;
							if (fill_put >= sfr_pkg::FILL_W'(sfr_pkg::BUF_DEPTH)) begin
								fill_d = '0;
								ev     = sfr_pkg::EV_OVERFLOW;
							end else begin
								fill_d = fill_put;
							end
						end
					end
				end
			end
			sfr_pkg::KIND_TICK: begin
				if (!ready_q) begin
					if (silence_q == 8'd1) begin
						if (fill_q != '0) begin
							ev = sfr_pkg::EV_TIMEOUT;
						end
						fill_d    = '0;
						silence_d = '0;
					end else if (silence_q > 8'd1) begin
						silence_d = silence_q - 8'd1;
					end
				end
			end
			sfr_pkg::KIND_RELEASE: begin
				if (ready_q) begin
					fill_d  = '0;
					ready_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_d = (wr.en && fill_q == sfr_pkg::FILL_W'(sfr_pkg::CMD_POS)) ? data : cmd_q;
	assign len_d = (wr.en && fill_q == sfr_pkg::FILL_W'(sfr_pkg::LEN_POS)) ? data : len_q;

	assign res.event_res   = ev;
	assign res.frame_ready = ready_d;
	assign res.position    = 8'(fill_d);
	assign res.command     = (fill_d >= sfr_pkg::FILL_W'(sfr_pkg::LEN_POS)) ? cmd_d : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			sum_q     <= sfr_pkg::SUM_SEED;
			ready_q   <= 1'b0;
			silence_q <= '0;
		end else if (accept) begin
			fill_q    <= fill_d;
			sum_q     <= sum_d;
			ready_q   <= ready_d;
			silence_q <= silence_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_d;
			len_q <= len_d;
		end
	end

endmodule

/* rtl/core/serial_frame_receiver.sv */
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------------
// input    | in_valid / in_ready  | kind, data, index
// result   | out_valid / out_ready| event_res, frame_ready, position, read_data, command
// config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless out_ready stalls; the result is registered at the transfer.
// Frame state updates on each transfer; buffer reads come from the registered RAM port.
// in_ready is high whenever the output register is empty or being taken this cycle.
// cfg_ready is always high. Reset clears frame state, flags and the output valid.
// The frame buffer is not cleared by reset.
module serial_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] data,
	input  logic [6:0] index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic       frame_ready,
	output logic [7:0] position,
	output logic [7:0] read_data,
	output logic [7:0] command,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	sfr_pkg::cfg_t    cfg_q;
	sfr_pkg::wr_req_t wr;
	sfr_pkg::result_t res, res_q;
	logic             accept;
	logic             out_valid_q;
	logic             rd_hit;
	logic             rd_en;
	logic             is_read_q;
	logic [7:0]       ram_rdata;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_reload <= sfr_pkg::TIMEOUT_RESET;
			cfg_q.sync_first     <= sfr_pkg::SYNC_FIRST_RESET;
			cfg_q.sync_second    <= sfr_pkg::SYNC_SECOND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfr_pkg::CFG_TIMEOUT:     cfg_q.timeout_reload <= cfg_data;
				sfr_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first     <= cfg_data;
				sfr_pkg::CFG_SYNC_SECOND: cfg_q.sync_second    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.data   (data),
		.cfg    (cfg_q),
		.wr     (wr),
		.res    (res)
	);

	assign rd_hit = (kind == sfr_pkg::KIND_READ) &&
	                (sfr_pkg::CMP_W'(index) < sfr_pkg::CMP_W'(sfr_pkg::BUF_DEPTH));
	assign rd_en  = accept && rd_hit;

	sfr_ram #(
		.WIDTH (8),
		.DEPTH (sfr_pkg::BUF_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (sfr_pkg::ADDR_W'(index)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= res;
			is_read_q <= rd_hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = res_q.event_res;
	assign frame_ready = res_q.frame_ready;
	assign position    = res_q.position;
	assign command     = res_q.command;
	assign read_data   = is_read_q ? ram_rdata : 8'd0;

`ifndef SYNTHESIS
	a_accept_sets_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == sfr_pkg::EV_ACCEPT) |-> frame_ready)
		else $error("accepted frame without ready flag");

	a_ready_holds_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_ready) |-> (position >= 8'd5))
		else $error("ready flag with a short frame");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wr.en) |-> !rd_en)
		else $error("buffer write and read from one item");

	a_discard_clears_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res == sfr_pkg::EV_BADSUM ||
		 event_res == sfr_pkg::EV_OVERFLOW || event_res == sfr_pkg::EV_TIMEOUT))
		|-> (position == 8'd0 && !frame_ready))
		else $error("discard left frame state behind");
`endif

endmodule
